[sv/ssr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ssr_pkg;

  localparam int SQ_W    = 6;
  localparam int KEY_W   = 7;
  localparam int SIZE_W  = 3;
  localparam int RANK_W  = 20;
  localparam int LANES   = 4;
  localparam int MAX_M   = 64;
  localparam int MAX_J   = 4;

  localparam logic [KEY_W-1:0] KEY_EMPTY = {KEY_W{1'b1}};

  typedef logic [SQ_W-1:0]   square_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [RANK_W-1:0] rank_t;

  typedef rank_t [MAX_M:0] binom_col_t;
  typedef binom_col_t [MAX_J:0] binom_tbl_t;

  typedef struct packed {
    logic                   pawn;
    size_t                  size;
    logic                   ok;
    logic [LANES-1:0][KEY_W-1:0] key;
  } sorted_t;

  function automatic binom_tbl_t build_binom();
    binom_tbl_t t;
    t = '0;
    for (int m = 0; m <= MAX_M; m++) begin
      t[0][m] = rank_t'(1);
      for (int j = 1; j <= MAX_J; j++) begin
        if (m > 0) begin
          t[j][m] = t[j-1][m-1] + t[j][m-1];
        end
      end
    end
    return t;
  endfunction

  localparam binom_tbl_t BINOM = build_binom();

  function automatic rank_t binom_get(logic [KEY_W-1:0] m, size_t j);
    rank_t r;
    r = '0;
    if (j <= size_t'(MAX_J) && m <= key_t'(MAX_M)) begin
      r = BINOM[j][m];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/square_subset_rank.sv]
// Throughput: one item per cycle while out_stall is low; the four register
// stages each hold one item and advance independently, so a stall only fills
// the bubbles ahead of it.
// Reset: synchronous, active low; it clears the stage valid bits only, and
// the block takes items in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module square_subset_rank #(
  parameter int SQUARES    = 64,
  parameter int PAWN_FIRST = 8,
  parameter int PAWN_END   = 56
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_pawn_mode,
  input  wire ssr_pkg::size_t   in_group_size,
  input  wire ssr_pkg::square_t in_square_a,
  input  wire ssr_pkg::square_t in_square_b,
  input  wire ssr_pkg::square_t in_square_c,
  input  wire ssr_pkg::square_t in_square_d,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output ssr_pkg::rank_t        out_rank,
  output logic                  out_found
);

  localparam int N_PAWN  = (PAWN_END > PAWN_FIRST) ? (PAWN_END - PAWN_FIRST) : 0;
  localparam int END_PWN = PAWN_FIRST + N_PAWN;

  logic             mid_valid;
  logic             mid_stall;
  ssr_pkg::sorted_t mid_item;

  ssr_sort #(
    .LO_P (PAWN_FIRST),
    .END_N(SQUARES),
    .END_P(END_PWN)
  ) u_sort (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pawn_mode (in_pawn_mode),
    .group_size(in_group_size),
    .square_a  (in_square_a),
    .square_b  (in_square_b),
    .square_c  (in_square_c),
    .square_d  (in_square_d),
    .out_valid (mid_valid),
    .out_stall (mid_stall),
    .out_item  (mid_item)
  );

  ssr_sum #(
    .LO_P (PAWN_FIRST),
    .END_N(SQUARES),
    .END_P(END_PWN)
  ) u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (mid_valid),
    .in_stall (mid_stall),
    .in_item  (mid_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rank (out_rank),
    .out_found(out_found)
  );

endmodule

`default_nettype wire

[sv/ssr_sort.sv]
`timescale 1ns / 1ps
`default_nettype none

module ssr_sort #(
  parameter int LO_P  = 8,
  parameter int END_N = 64,
  parameter int END_P = 56
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             pawn_mode,
  input  wire ssr_pkg::size_t   group_size,
  input  wire ssr_pkg::square_t square_a,
  input  wire ssr_pkg::square_t square_b,
  input  wire ssr_pkg::square_t square_c,
  input  wire ssr_pkg::square_t square_d,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output ssr_pkg::sorted_t      out_item
);

  localparam ssr_pkg::key_t LO_P_K  = ssr_pkg::key_t'(LO_P);
  localparam ssr_pkg::key_t END_N_K = ssr_pkg::key_t'(END_N);
  localparam ssr_pkg::key_t END_P_K = ssr_pkg::key_t'(END_P);

  logic             s1_valid_r;
  ssr_pkg::sorted_t s1_r;
  ssr_pkg::sorted_t s1_nxt;
  logic             s2_valid_r;
  ssr_pkg::sorted_t s2_r;
  ssr_pkg::sorted_t s2_nxt;
  logic             s1_ready;
  logic             s2_ready;

  assign s2_ready = !s2_valid_r || !out_stall;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_stall = !s1_ready;

  always_comb begin
    ssr_pkg::square_t sq [ssr_pkg::LANES];
    ssr_pkg::key_t    k  [ssr_pkg::LANES];
    ssr_pkg::key_t    lo;
    ssr_pkg::key_t    hi;
    logic             ok;
    sq[0] = square_a;
    sq[1] = square_b;
    sq[2] = square_c;
    sq[3] = square_d;
    lo = pawn_mode ? LO_P_K : '0;
    hi = pawn_mode ? END_P_K : END_N_K;
    ok = (group_size >= ssr_pkg::size_t'(1)) && (group_size <= ssr_pkg::size_t'(ssr_pkg::LANES));
    for (int i = 0; i < ssr_pkg::LANES; i++) begin
      if (ssr_pkg::size_t'(i) < group_size) begin
        k[i] = {1'b0, sq[i]};
        if (k[i] < lo || k[i] >= hi) begin
          ok = 1'b0;
        end
      end else begin
        k[i] = ssr_pkg::KEY_EMPTY;
      end
    end
    s1_nxt.pawn = pawn_mode;
    s1_nxt.size = group_size;
    s1_nxt.ok   = ok;
    s1_nxt.key[0] = (k[0] < k[1]) ? k[0] : k[1];
    s1_nxt.key[1] = (k[0] < k[1]) ? k[1] : k[0];
    s1_nxt.key[2] = (k[2] < k[3]) ? k[2] : k[3];
    s1_nxt.key[3] = (k[2] < k[3]) ? k[3] : k[2];
  end

  always_comb begin
    ssr_pkg::key_t a0;
    ssr_pkg::key_t a1;
    ssr_pkg::key_t a2;
    ssr_pkg::key_t a3;
    a0 = (s1_r.key[0] < s1_r.key[2]) ? s1_r.key[0] : s1_r.key[2];
    a2 = (s1_r.key[0] < s1_r.key[2]) ? s1_r.key[2] : s1_r.key[0];
    a1 = (s1_r.key[1] < s1_r.key[3]) ? s1_r.key[1] : s1_r.key[3];
    a3 = (s1_r.key[1] < s1_r.key[3]) ? s1_r.key[3] : s1_r.key[1];
    s2_nxt = s1_r;
    s2_nxt.key[0] = a0;
    s2_nxt.key[1] = (a1 < a2) ? a1 : a2;
    s2_nxt.key[2] = (a1 < a2) ? a2 : a1;
    s2_nxt.key[3] = a3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_r <= s1_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_item  = s2_r;

endmodule

`default_nettype wire

[sv/ssr_sum.sv]
`timescale 1ns / 1ps
`default_nettype none

module ssr_sum #(
  parameter int LO_P  = 8,
  parameter int END_N = 64,
  parameter int END_P = 56
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire ssr_pkg::sorted_t in_item,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output ssr_pkg::rank_t        out_rank,
  output logic                  out_found
);

  localparam ssr_pkg::key_t END_N_K = ssr_pkg::key_t'(END_N);
  localparam ssr_pkg::key_t END_P_K = ssr_pkg::key_t'(END_P);
  localparam ssr_pkg::key_t SIZE_P_K = ssr_pkg::key_t'(END_P - LO_P);

  logic                                  s3_valid_r;
  logic                                  s3_ok_r;
  logic                                  s3_ok_nxt;
  ssr_pkg::rank_t                        s3_total_r;
  ssr_pkg::rank_t                        s3_total_nxt;
  logic [ssr_pkg::LANES-1:0][ssr_pkg::RANK_W-1:0] s3_term_r;
  logic [ssr_pkg::LANES-1:0][ssr_pkg::RANK_W-1:0] s3_term_nxt;
  logic                                  s4_valid_r;
  ssr_pkg::rank_t                        s4_rank_r;
  ssr_pkg::rank_t                        s4_rank_nxt;
  logic                                  s4_found_r;
  logic                                  s3_ready;
  logic                                  s4_ready;

  assign s4_ready = !s4_valid_r || !out_stall;
  assign s3_ready = !s3_valid_r || s4_ready;
  assign in_stall = !s3_ready;

  always_comb begin
    ssr_pkg::key_t hi;
    ssr_pkg::key_t n;
    ssr_pkg::key_t d;
    logic          ok;
    hi = in_item.pawn ? END_P_K : END_N_K;
    n  = in_item.pawn ? SIZE_P_K : END_N_K;
    ok = in_item.ok;
    for (int i = 1; i < ssr_pkg::LANES; i++) begin
      if (ssr_pkg::size_t'(i) < in_item.size && in_item.key[i] == in_item.key[i-1]) begin
        ok = 1'b0;
      end
    end
    for (int i = 0; i < ssr_pkg::LANES; i++) begin
      d = hi - ssr_pkg::key_t'(1) - in_item.key[i];
      if (ok && ssr_pkg::size_t'(i) < in_item.size) begin
        s3_term_nxt[i] = ssr_pkg::binom_get({1'b0, d[ssr_pkg::SQ_W-1:0]},
                                            in_item.size - ssr_pkg::size_t'(i));
      end else begin
        s3_term_nxt[i] = '0;
      end
    end
    s3_ok_nxt    = ok;
    s3_total_nxt = ok ? ssr_pkg::binom_get(n, in_item.size) - ssr_pkg::rank_t'(1) : '0;
  end

  assign s4_rank_nxt = s3_total_r - (s3_term_r[0] + s3_term_r[1] + s3_term_r[2] + s3_term_r[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_valid_r <= in_valid;
      end
      if (s4_ready) begin
        s4_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && in_valid) begin
      s3_ok_r    <= s3_ok_nxt;
      s3_total_r <= s3_total_nxt;
      s3_term_r  <= s3_term_nxt;
    end
    if (s4_ready && s3_valid_r) begin
      s4_rank_r  <= s4_rank_nxt;
      s4_found_r <= s3_ok_r;
    end
  end

  assign out_valid = s4_valid_r;
  assign out_rank  = s4_rank_r;
  assign out_found = s4_found_r;

endmodule

`default_nettype wire
